// ----- rtl/thlc_pkg.sv -----
// thlc_pkg: shared types, constants and the square root step function
// for the temporal history luma clamp unit; no dependencies
`default_nettype none

package thlc_pkg;

  localparam int LUMA_FRAC_BITS = 12;
  localparam int VAR_FRAC_BITS  = 2 * LUMA_FRAC_BITS - 4;
  localparam int SQRT_FRAC_BITS = VAR_FRAC_BITS / 2;
  localparam int SIGMA_SHIFT    = LUMA_FRAC_BITS - SQRT_FRAC_BITS;

  localparam int LUMA_W  = 16;
  localparam int VAR_W   = 24;
  localparam int ROOT_W  = VAR_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int Y_W     = 18;
  localparam int RECIP_W = 20;
  localparam int RECIP_SHIFT = 22;
  localparam int PROD_W  = Y_W + RECIP_W;

  // ceil(2^22 / 5): exact quotient for every 18 bit dividend
  localparam logic [RECIP_W-1:0] RECIP_FIVE = RECIP_W'(838861);

  localparam int STEPS_PER_STAGE = 4;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic REG_TEMPORAL_CAP   = 1'b0;
  localparam logic REG_MIN_HALF_RANGE = 1'b1;

  typedef struct packed {
    logic [Y_W-1:0]    span_scaled;
    logic [LUMA_W-1:0] center;
    logic [LUMA_W-1:0] mean;
    logic [VAR_W-1:0]  variance;
    logic [LUMA_W-1:0] hist;
  } item_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [VAR_W-1:0]  rad;
  } sqrt_t;

  typedef struct packed {
    logic [LUMA_W-1:0] temporal_cap;
    logic [LUMA_W-1:0] min_half_range;
  } cfg_t;

  // one radix-4 digit of the integer square root
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t             r;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    cur   = {s.rem[REM_W-3:0], s.rad[VAR_W-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    r.rad = {s.rad[VAR_W-3:0], 2'b00};
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/thlc_front.sv -----
// thlc_front: takes a pixel word, orders the bounds, clamps negative operands
// to zero and forms span and centre; uses thlc_pkg
`default_nettype none

module thlc_front (
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire logic [15:0]          nbr_min_luma,
  input  wire logic [15:0]          nbr_max_luma,
  input  wire logic signed [16:0]   prev_mean_luma,
  input  wire logic signed [24:0]   prev_variance,
  input  wire logic signed [16:0]   history_luma,
  output logic                      push,
  output thlc_pkg::item_t           item
);

  logic [15:0] lo;
  logic [15:0] hi;
  logic [15:0] span;
  logic [19:0] span_x11;
  logic [16:0] bound_sum;

  always_comb begin
    push = start && !busy;
    if (nbr_max_luma < nbr_min_luma) begin
      lo = nbr_max_luma;
      hi = nbr_min_luma;
    end else begin
      lo = nbr_min_luma;
      hi = nbr_max_luma;
    end
    span      = hi - lo;
    span_x11  = {1'b0, span, 3'b000} + {3'b000, span, 1'b0} + {4'b0000, span} + 20'd10;
    bound_sum = {1'b0, lo} + {1'b0, hi};

    item.span_scaled = span_x11[19:2];
    item.center      = bound_sum[16:1];
    item.mean        = prev_mean_luma[16] ? '0 : prev_mean_luma[15:0];
    item.variance    = prev_variance[24] ? '0 : prev_variance[23:0];
    item.hist        = history_luma[16] ? '0 : history_luma[15:0];
  end

endmodule

`default_nettype wire

// ----- rtl/thlc_queue.sv -----
// thlc_queue: short queue of classified words between front and back
// uses thlc_pkg
`default_nettype none

module thlc_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire thlc_pkg::item_t  wdata,
  input  wire logic             pop,
  output logic                  full,
  output logic                  nonempty,
  output thlc_pkg::item_t       rdata
);

  thlc_pkg::item_t                 mem [thlc_pkg::QUEUE_DEPTH];
  logic [thlc_pkg::QPTR_W-1:0]     wptr;
  logic [thlc_pkg::QPTR_W-1:0]     rptr;
  logic [thlc_pkg::QCNT_W-1:0]     count;
  logic                            do_pop;

  always_comb begin
    full     = (count == thlc_pkg::QCNT_W'(thlc_pkg::QUEUE_DEPTH));
    nonempty = (count != '0);
    do_pop   = pop && nonempty;
    rdata    = mem[rptr];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/thlc_back.sv -----
// thlc_back: five stage pipeline for spatial and temporal half ranges,
// square root and the final clamp; uses thlc_pkg
`default_nettype none

module thlc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire thlc_pkg::item_t  item,
  input  wire thlc_pkg::cfg_t   cfg,
  output logic                  done,
  output logic [15:0]           clamped_history,
  output logic [15:0]           half_range
);

  localparam int LW = thlc_pkg::LUMA_W;

  logic [3:0] vld;

  // stage 1
  logic [thlc_pkg::PROD_W-1:0] s1_prod;
  thlc_pkg::sqrt_t             s1_sq;
  logic [LW-1:0]               s1_center;
  logic [LW-1:0]               s1_mean;
  logic [LW-1:0]               s1_hist;
  // stage 2
  logic [LW-1:0]               s2_spatial;
  thlc_pkg::sqrt_t             s2_sq;
  logic [LW-1:0]               s2_center;
  logic [LW-1:0]               s2_mean;
  logic [LW-1:0]               s2_hist;
  // stage 3
  logic [LW-1:0]               s3_spatial;
  logic [LW:0]                 s3_temporal;
  logic [LW-1:0]               s3_center;
  logic [LW-1:0]               s3_hist;
  // stage 4
  logic [LW-1:0]               s4_h;
  logic [LW-1:0]               s4_center;
  logic [LW-1:0]               s4_hist;

  thlc_pkg::sqrt_t             sq_a [thlc_pkg::STEPS_PER_STAGE+1];
  thlc_pkg::sqrt_t             sq_b [thlc_pkg::STEPS_PER_STAGE+1];
  thlc_pkg::sqrt_t             sq_c [thlc_pkg::STEPS_PER_STAGE+1];
  logic [LW-1:0]               quot;
  logic [LW-1:0]               spatial;
  logic [LW:0]                 sigma_term;
  logic [LW-1:0]               temporal;
  logic [LW-1:0]               h;
  logic [LW-1:0]               lower;
  logic [LW:0]                 upper;
  logic [LW-1:0]               res;

  always_comb begin
    sq_a[0] = '{rem: '0, root: '0, rad: item.variance};
    for (int i = 0; i < thlc_pkg::STEPS_PER_STAGE; i++) begin
      sq_a[i+1] = thlc_pkg::sqrt_step(sq_a[i]);
    end
    sq_b[0] = s1_sq;
    for (int i = 0; i < thlc_pkg::STEPS_PER_STAGE; i++) begin
      sq_b[i+1] = thlc_pkg::sqrt_step(sq_b[i]);
    end
    sq_c[0] = s2_sq;
    for (int i = 0; i < thlc_pkg::STEPS_PER_STAGE; i++) begin
      sq_c[i+1] = thlc_pkg::sqrt_step(sq_c[i]);
    end

    quot       = s1_prod[thlc_pkg::RECIP_SHIFT +: LW];
    spatial    = (quot < cfg.min_half_range) ? cfg.min_half_range : quot;

    sigma_term = (LW+1)'(sq_c[thlc_pkg::STEPS_PER_STAGE].root) << (thlc_pkg::SIGMA_SHIFT + 1);

    temporal   = (s3_temporal > {1'b0, cfg.temporal_cap}) ? cfg.temporal_cap
                                                           : s3_temporal[LW-1:0];
    h          = (s3_spatial > temporal) ? s3_spatial : temporal;

    lower      = (s4_center > s4_h) ? (s4_center - s4_h) : '0;
    upper      = {1'b0, s4_center} + {1'b0, s4_h};
    if (s4_hist < lower) begin
      res = lower;
    end else if ({1'b0, s4_hist} > upper) begin
      res = upper[LW-1:0];
    end else begin
      res = s4_hist;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod     <= item.span_scaled * thlc_pkg::RECIP_FIVE;
    s1_sq       <= sq_a[thlc_pkg::STEPS_PER_STAGE];
    s1_center   <= item.center;
    s1_mean     <= item.mean;
    s1_hist     <= item.hist;

    s2_spatial  <= spatial;
    s2_sq       <= sq_b[thlc_pkg::STEPS_PER_STAGE];
    s2_center   <= s1_center;
    s2_mean     <= s1_mean;
    s2_hist     <= s1_hist;

    s3_spatial  <= s2_spatial;
    s3_temporal <= {1'b0, s2_mean} + sigma_term;
    s3_center   <= s2_center;
    s3_hist     <= s2_hist;

    s4_h        <= h;
    s4_center   <= s3_center;
    s4_hist     <= s3_hist;

    clamped_history <= res;
    half_range      <= s4_h;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[2:0], in_valid};
      done <= vld[3];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/temporal_history_luma_clamp_unit.sv -----
// temporal_history_luma_clamp_unit: top level with register port, front,
// queue and back pipeline; uses thlc_pkg, thlc_front, thlc_queue, thlc_back
`default_nettype none

// One pixel word is taken per clock while busy is low, and its result shows
// on clamped_history and half_range with done high for one cycle. Words leave
// in the order they came. The back pipeline drains one word every clock and
// the receiver cannot stall it, so the two-word queue never fills and busy
// stays low; the square root runs as twelve radix-4 steps spread over three
// pipeline stages, which sets the depth. Registers: temporal_cap at 0x0,
// min_half_range at 0x4; the user writes them only while no word is in
// flight, and the block does not enforce it.
module temporal_history_luma_clamp_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [15:0]         nbr_min_luma,
  input  wire logic [15:0]         nbr_max_luma,
  input  wire logic signed [16:0]  prev_mean_luma,
  input  wire logic signed [24:0]  prev_variance,
  input  wire logic signed [16:0]  history_luma,
  output logic                     done,
  output logic [15:0]              clamped_history,
  output logic [15:0]              half_range
);

  thlc_pkg::cfg_t   cfg;
  thlc_pkg::item_t  front_item;
  thlc_pkg::item_t  head_item;
  logic             push;
  logic             nonempty;
  logic             reg_write;

  always_comb begin
    pready    = 1'b1;
    reg_write = psel && penable && pwrite && pready;
    unique case (paddr[2])
      thlc_pkg::REG_TEMPORAL_CAP:   prdata = {16'h0000, cfg.temporal_cap};
      thlc_pkg::REG_MIN_HALF_RANGE: prdata = {16'h0000, cfg.min_half_range};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temporal_cap   <= 16'd328;
      cfg.min_half_range <= 16'd1;
    end else if (reg_write) begin
      if (paddr[2] == thlc_pkg::REG_TEMPORAL_CAP) begin
        cfg.temporal_cap <= pwdata[15:0];
      end else begin
        cfg.min_half_range <= pwdata[15:0];
      end
    end
  end

  thlc_front u_front (
    .start          (start),
    .busy           (busy),
    .nbr_min_luma   (nbr_min_luma),
    .nbr_max_luma   (nbr_max_luma),
    .prev_mean_luma (prev_mean_luma),
    .prev_variance  (prev_variance),
    .history_luma   (history_luma),
    .push           (push),
    .item           (front_item)
  );

  thlc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (front_item),
    .pop      (nonempty),
    .full     (busy),
    .nonempty (nonempty),
    .rdata    (head_item)
  );

  thlc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (nonempty),
    .item            (head_item),
    .cfg             (cfg),
    .done            (done),
    .clamped_history (clamped_history),
    .half_range      (half_range)
  );

endmodule

`default_nettype wire

// ----- test/thlc_checker.sv -----
// thlc_checker: watches the register port and the pixel word channels of the
// history clamp unit, predicts each result and compares it; uses thlc_pkg
`default_nettype none

module thlc_checker (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  input  wire logic                pready,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [15:0]         nbr_min_luma,
  input  wire logic [15:0]         nbr_max_luma,
  input  wire logic signed [16:0]  prev_mean_luma,
  input  wire logic signed [24:0]  prev_variance,
  input  wire logic signed [16:0]  history_luma,
  input  wire logic                done,
  input  wire logic [15:0]         clamped_history,
  input  wire logic [15:0]         half_range,
  output int                       errors,
  output int                       pending
);

  localparam logic [thlc_pkg::LUMA_W-1:0] CAP_AT_RESET   = 16'd328;
  localparam logic [thlc_pkg::LUMA_W-1:0] FLOOR_AT_RESET = 16'd1;

  typedef struct packed {
    logic [thlc_pkg::LUMA_W-1:0] clamped;
    logic [thlc_pkg::LUMA_W-1:0] range_q;
  } window_t;

  window_t                     window_q [$];
  logic [thlc_pkg::LUMA_W-1:0] cap_q;
  logic [thlc_pkg::LUMA_W-1:0] floor_q;

  function automatic window_t clamp_history(
    input logic [15:0] a,
    input logic [15:0] b,
    input logic [16:0] m,
    input logic [24:0] v,
    input logic [16:0] h,
    input logic [15:0] cap,
    input logic [15:0] flo
  );
    logic [15:0] lo;
    logic [15:0] hi;
    logic [31:0] mean_p;
    logic [31:0] var_p;
    logic [31:0] hist_p;
    logic [31:0] root;
    logic [31:0] trial;
    logic [31:0] spatial;
    logic [31:0] temporal;
    logic [31:0] width;
    logic [31:0] mid;
    logic [31:0] bottom;
    logic [31:0] top_w;
    logic [31:0] pick;
    window_t     r;
    lo     = (b < a) ? b : a;
    hi     = (b < a) ? a : b;
    mean_p = m[16] ? 32'd0 : {16'b0, m[15:0]};
    var_p  = v[24] ? 32'd0 : {8'b0, v[23:0]};
    hist_p = h[16] ? 32'd0 : {16'b0, h[15:0]};
    // 0.55 of the span, halves rounded up
    spatial = ({16'b0, hi - lo} * 32'd11 + 32'd10) / 32'd20;
    if (spatial < {16'b0, flo}) spatial = {16'b0, flo};
    root = 32'd0;
    for (int k = 11; k >= 0; k--) begin
      trial = root | (32'd1 << k);
      if (trial * trial <= var_p) root = trial;
    end
    // sigma from Q2.10 up to Q4.12, then mean plus two sigma
    temporal = mean_p + 32'd2 * (root << 2);
    if (temporal > {16'b0, cap}) temporal = {16'b0, cap};
    width  = (spatial > temporal) ? spatial : temporal;
    mid    = ({16'b0, lo} + {16'b0, hi}) >> 1;
    bottom = (mid > width) ? mid - width : 32'd0;
    top_w  = mid + width;
    pick   = hist_p;
    if (pick < bottom) pick = bottom;
    else if (pick > top_w) pick = top_w;
    r.clamped = pick[15:0];
    r.range_q = width[15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    window_t want;
    int      bad;
    bad = 0;
    if (rst) begin
      window_q.delete();
      cap_q   <= CAP_AT_RESET;
      floor_q <= FLOOR_AT_RESET;
      errors  <= 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == thlc_pkg::REG_TEMPORAL_CAP) cap_q <= pwdata[15:0];
        if (paddr[2] == thlc_pkg::REG_MIN_HALF_RANGE) floor_q <= pwdata[15:0];
      end
      if (done) begin
        if (window_q.size() == 0) begin
          $error("result word with nothing expected: clamped_history %0d, half_range %0d",
                 clamped_history, half_range);
          bad++;
        end else begin
          want = window_q.pop_front();
          if (clamped_history !== want.clamped) begin
            $error("clamped_history: expected %0d, got %0d", want.clamped, clamped_history);
            bad++;
          end
          if (half_range !== want.range_q) begin
            $error("half_range: expected %0d, got %0d", want.range_q, half_range);
            bad++;
          end
        end
      end
      if (start && !busy) begin
        window_q.insert(window_q.size(),
                        clamp_history(nbr_min_luma, nbr_max_luma, prev_mean_luma,
                                      prev_variance, history_luma, cap_q, floor_q));
      end
      errors  <= errors + bad;
      pending <= window_q.size();
    end
  end

endmodule

`default_nettype wire

// ----- test/tb_temporal_history_luma_clamp_unit.sv -----
// tb_temporal_history_luma_clamp_unit: drives register writes and pixel words
// into the history clamp unit and gives the verdict; uses thlc_pkg,
// thlc_checker and temporal_history_luma_clamp_unit
`default_nettype none

module tb_temporal_history_luma_clamp_unit;

  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_WORDS  = 240;
  localparam int N_SETTINGS   = 6;

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [2:0]         paddr          = 3'd0;
  logic [31:0]        pwdata         = 32'd0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start          = 1'b0;
  logic               busy;
  logic [15:0]        nbr_min_luma   = 16'd0;
  logic [15:0]        nbr_max_luma   = 16'd0;
  logic signed [16:0] prev_mean_luma = 17'sd0;
  logic signed [24:0] prev_variance  = 25'sd0;
  logic signed [16:0] history_luma   = 17'sd0;
  logic               done;
  logic [15:0]        clamped_history;
  logic [15:0]        half_range;
  int                 errors;
  int                 pending;
  int                 n_words        = 0;
  int                 quiet_cycles   = 0;

  always #4 clk = ~clk;

  temporal_history_luma_clamp_unit u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .nbr_min_luma(nbr_min_luma), .nbr_max_luma(nbr_max_luma),
    .prev_mean_luma(prev_mean_luma), .prev_variance(prev_variance),
    .history_luma(history_luma),
    .done(done), .clamped_history(clamped_history), .half_range(half_range)
  );

  thlc_checker u_chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready),
    .start(start), .busy(busy),
    .nbr_min_luma(nbr_min_luma), .nbr_max_luma(nbr_max_luma),
    .prev_mean_luma(prev_mean_luma), .prev_variance(prev_variance),
    .history_luma(history_luma),
    .done(done), .clamped_history(clamped_history), .half_range(half_range),
    .errors(errors), .pending(pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sender idle share by progress through the run
  function automatic int idle_share(input int words);
    if (words < 567) return 9;
    if (words < 1133) return 59;
    return 0;
  endfunction

  function automatic logic [31:0] corner_val(input int w);
    case ($urandom_range(3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << (w - 1);
      default: return (32'd1 << (w - 1)) - 32'd1;
    endcase
  endfunction

  task automatic write_reg(input logic sel, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(input logic [15:0] a, input logic [15:0] b, input logic [16:0] m,
                           input logic [24:0] v, input logic [16:0] h);
    logic took;
    while ($urandom_range(99) < idle_share(n_words)) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    nbr_min_luma   <= a;
    nbr_max_luma   <= b;
    prev_mean_luma <= m;
    prev_variance  <= v;
    history_luma   <= h;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    n_words++;
  endtask

  task automatic send_random;
    int          style;
    int          span;
    int          c;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] t;
    logic [16:0] m;
    logic [24:0] v;
    logic [16:0] h;
    style = $urandom_range(9);
    if (style < 5) begin
      // plausible pixel: narrow neighbourhood, modest statistics, history near it
      a    = 16'($urandom);
      span = ($urandom_range(4) == 0) ? 0 : $urandom_range(0, (1 << $urandom_range(1, 16)) - 1);
      b    = (int'(a) + span > 65535) ? 16'hFFFF : 16'(int'(a) + span);
      span = int'(b) - int'(a);
      m    = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 4000));
      v    = 25'($urandom & ((1 << $urandom_range(1, 24)) - 1));
      c    = (int'(a) + int'(b)) / 2 + int'($urandom_range(0, 2 * span + 800)) - (span + 400);
      if (c > 65535) c = 65535;
      if (c < -65536) c = -65536;
      h    = 17'(c);
      if ($urandom_range(3) == 0) begin
        t = a;
        a = b;
        b = t;
      end
    end else if (style < 8) begin
      a = 16'($urandom);
      b = 16'($urandom);
      m = 17'($urandom);
      v = 25'($urandom);
      h = 17'($urandom);
    end else begin
      a = 16'(corner_val(16));
      b = 16'(corner_val(16));
      m = 17'(corner_val(17));
      v = 25'(corner_val(25));
      h = 17'(corner_val(17));
    end
    send_word(a, b, m, v, h);
  endtask

  task automatic drain;
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] caps   [N_SETTINGS];
    logic [15:0] floors [N_SETTINGS];
    caps   = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'd0, 16'd0};
    floors = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001, 16'd0, 16'd0};
    caps[4]   = 16'($urandom);
    floors[4] = 16'($urandom_range(1, 65535));
    caps[5]   = 16'($urandom_range(0, 2000));
    floors[5] = 16'($urandom_range(1, 300));
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(16'd0, 16'd0, 17'd0, 25'd0, 17'd0);
    send_word(16'd0, 16'hFFFF, 17'd0, 25'd0, 17'h0FFFF);
    send_word(16'hFFFF, 16'd0, 17'd0, 25'd0, 17'd0);
    send_word(16'd1000, 16'd1000, 17'd0, 25'd0, 17'd5000);
    send_word(16'd30000, 16'd30100, 17'h10000, 25'h1000000, 17'h10000);
    send_word(16'd30000, 16'd30100, 17'h0FFFF, 25'd0, 17'h0FFFF);
    send_word(16'd20000, 16'd20010, 17'd0, 25'h0FFFFFF, 17'd0);
    send_word(16'd20000, 16'd20010, 17'd100, 25'd1048576, 17'd40000);
    send_word(16'd40000, 16'd40200, 17'd0, 25'd0, 17'd100);
    send_word(16'd100, 16'd300, 17'd0, 25'd0, 17'd60000);
    send_word(16'd100, 16'd300, 17'd0, 25'd0, 17'd200);
    send_word(16'hFFFF, 16'hFFFF, 17'd0, 25'd0, 17'h0FFFF);
    send_word(16'd0, 16'd1, 17'd0, 25'd0, 17'd1);
    send_word(16'd0, 16'd2, 17'd0, 25'd0, 17'd3);
    send_word(16'd0, 16'd10, 17'd0, 25'd0, 17'd0);
    send_word(16'hFFFF, 16'hFFFE, 17'd0, 25'd0, 17'h1FFFF);
    send_word(16'd500, 16'd600, 17'h1FFFF, 25'h1FFFFFF, 17'd550);
    send_word(16'd500, 16'd600, 17'd0, 25'd1, 17'd1000);
    send_word(16'd60000, 16'd61000, 17'd328, 25'd0, 17'h0FFFF);
    send_word(16'd8000, 16'd4000, 17'd50, 25'd4096, 17'd7000);
    for (int i = 0; i < PHASE_WORDS; i++) send_random();
    drain();

    for (int s = 0; s < N_SETTINGS; s++) begin
      write_reg(thlc_pkg::REG_TEMPORAL_CAP, caps[s]);
      write_reg(thlc_pkg::REG_MIN_HALF_RANGE, floors[s]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (s == 2 && i == PHASE_WORDS / 2) drain();
        send_random();
      end
      drain();
    end

    repeat (12) @(posedge clk);
    $display("covered %0d pixel words over %0d register settings incl. zero floor and caps",
             n_words, N_SETTINGS + 1);
    $display("sender idled at 9%%, then 59%%, then not at all; %0d mismatches", errors);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
